/* sv/ps2sa_pkg.sv */
package ps2sa_pkg;

    // Scan codes that the decoder treats specially.
    localparam logic [7:0] CODE_NONE      = 8'h00;
    localparam logic [7:0] CODE_ACK       = 8'hFA;
    localparam logic [7:0] CODE_BREAK     = 8'hF0;
    localparam logic [7:0] CODE_EXTEND    = 8'hE0;
    localparam logic [7:0] CODE_LSHIFT    = 8'h12;
    localparam logic [7:0] CODE_RSHIFT    = 8'h59;
    localparam logic [7:0] CODE_CTRL      = 8'h14;
    localparam logic [7:0] CODE_ALT       = 8'h11;
    localparam logic [7:0] CODE_CAPS      = 8'h58;
    localparam logic [7:0] CODE_NUM       = 8'h77;
    localparam logic [7:0] CODE_SCROLL    = 8'h7E;
    localparam logic [7:0] CODE_UP        = 8'h75;
    localparam logic [7:0] CODE_DOWN      = 8'h72;
    localparam logic [7:0] CODE_LEFT      = 8'h6B;
    localparam logic [7:0] CODE_RIGHT     = 8'h74;
    localparam logic [7:0] CODE_INSERT    = 8'h70;
    localparam logic [7:0] CODE_DELETE    = 8'h71;
    localparam logic [7:0] CODE_HOME      = 8'h6C;
    localparam logic [7:0] CODE_END       = 8'h69;
    localparam logic [7:0] CODE_PGUP      = 8'h7D;
    localparam logic [7:0] CODE_PGDN      = 8'h7A;

    // Control codes sent for the navigation keys.
    localparam logic [7:0] NAV_UP    = 8'd5;
    localparam logic [7:0] NAV_DOWN  = 8'd24;
    localparam logic [7:0] NAV_LEFT  = 8'd16;
    localparam logic [7:0] NAV_RIGHT = 8'd4;
    localparam logic [7:0] NAV_OTHER = 8'd1;

    localparam logic [7:0] CTRL_MASK = 8'h1F;
    localparam logic [7:0] CASE_FLIP = 8'd32;

    localparam int TABLE_LEN = 132;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_LEDS = 2'd1,
        KIND_ACK  = 2'd2
    } t_kind;

    // Keyboard state carried from one byte to the next.
    typedef struct packed {
        logic       shift_held;
        logic       ctrl_held;
        logic       caps_lock;
        logic       num_lock;
        logic       scroll_lock;
        logic [7:0] previous_code;
    } t_kbd_state;

    // One decoded result.
    typedef struct packed {
        logic       emit;
        t_kind      kind;
        logic [7:0] value;
    } t_result;

    // Unshifted UK layout.
    localparam logic [7:0] PLAIN_MAP [0:TABLE_LEN-1] = '{
        8'd0,   8'd137, 8'd0,   8'd133, 8'd131, 8'd129, 8'd130, 8'd140,
        8'd0,   8'd138, 8'd136, 8'd134, 8'd132, 8'd7,   8'd6,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd113, 8'd49,  8'd0,
        8'd0,   8'd0,   8'd122, 8'd115, 8'd97,  8'd119, 8'd50,  8'd0,
        8'd0,   8'd99,  8'd120, 8'd100, 8'd101, 8'd52,  8'd51,  8'd59,
        8'd0,   8'd32,  8'd118, 8'd102, 8'd116, 8'd114, 8'd53,  8'd0,
        8'd0,   8'd110, 8'd98,  8'd104, 8'd103, 8'd121, 8'd54,  8'd7,
        8'd8,   8'd44,  8'd109, 8'd106, 8'd117, 8'd55,  8'd56,  8'd0,
        8'd0,   8'd44,  8'd107, 8'd105, 8'd111, 8'd48,  8'd57,  8'd0,
        8'd0,   8'd46,  8'd47,  8'd108, 8'd59,  8'd112, 8'd45,  8'd0,
        8'd0,   8'd0,   8'd39,  8'd0,   8'd91,  8'd61,  8'd0,   8'd0,
        8'd0,   8'd0,   8'd13,  8'd93,  8'd0,   8'd35,  8'd0,   8'd0,
        8'd0,   8'd92,  8'd0,   8'd0,   8'd0,   8'd0,   8'd8,   8'd0,
        8'd0,   8'd49,  8'd0,   8'd52,  8'd55,  8'd0,   8'd0,   8'd0,
        8'd48,  8'd46,  8'd50,  8'd53,  8'd54,  8'd56,  8'd3,   8'd0,
        8'd139, 8'd43,  8'd51,  8'd45,  8'd42,  8'd57,  8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd135
    };

    // Shifted UK layout.
    localparam logic [7:0] SHIFT_MAP [0:TABLE_LEN-1] = '{
        8'd0,   8'd149, 8'd0,   8'd145, 8'd143, 8'd141, 8'd142, 8'd152,
        8'd0,   8'd150, 8'd148, 8'd146, 8'd144, 8'd0,   8'd172, 8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd81,  8'd33,  8'd0,
        8'd0,   8'd0,   8'd90,  8'd83,  8'd65,  8'd87,  8'd34,  8'd0,
        8'd0,   8'd67,  8'd88,  8'd68,  8'd69,  8'd36,  8'd163, 8'd58,
        8'd0,   8'd32,  8'd86,  8'd70,  8'd84,  8'd82,  8'd37,  8'd0,
        8'd0,   8'd78,  8'd66,  8'd72,  8'd71,  8'd89,  8'd94,  8'd0,
        8'd0,   8'd76,  8'd77,  8'd74,  8'd85,  8'd38,  8'd42,  8'd0,
        8'd0,   8'd60,  8'd75,  8'd73,  8'd79,  8'd41,  8'd40,  8'd0,
        8'd0,   8'd62,  8'd63,  8'd76,  8'd58,  8'd80,  8'd95,  8'd0,
        8'd0,   8'd0,   8'd64,  8'd0,   8'd123, 8'd43,  8'd0,   8'd0,
        8'd0,   8'd0,   8'd13,  8'd125, 8'd0,   8'd126, 8'd0,   8'd0,
        8'd0,   8'd124, 8'd0,   8'd0,   8'd0,   8'd0,   8'd8,   8'd0,
        8'd0,   8'd49,  8'd0,   8'd52,  8'd55,  8'd0,   8'd0,   8'd0,
        8'd48,  8'd46,  8'd50,  8'd53,  8'd54,  8'd56,  8'd3,   8'd0,
        8'd151, 8'd43,  8'd51,  8'd45,  8'd42,  8'd57,  8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd135
    };

    // Control code of a navigation key, or zero for any other key.
    function automatic logic [7:0] nav_code(input logic [7:0] code);
        logic [7:0] nav;
        nav = 8'd0;
        case (code)
            CODE_UP:    nav = NAV_UP;
            CODE_DOWN:  nav = NAV_DOWN;
            CODE_LEFT:  nav = NAV_LEFT;
            CODE_RIGHT: nav = NAV_RIGHT;
            CODE_INSERT, CODE_DELETE, CODE_HOME,
            CODE_END, CODE_PGUP, CODE_PGDN: nav = NAV_OTHER;
            default:    nav = 8'd0;
        endcase
        return nav;
    endfunction

endpackage

/* sv/ps2sa_decode.sv */
module ps2sa_decode (
    input  logic [7:0]            i_code,
    input  ps2sa_pkg::t_kbd_state i_state,
    output ps2sa_pkg::t_kbd_state o_state,
    output ps2sa_pkg::t_result    o_result
);
    import ps2sa_pkg::*;

    logic [7:0] nav;
    logic [7:0] ch;
    logic [7:0] ch_case;
    logic       nav_enable;
    logic       in_table;

    // Navigation lookup applies after an extend prefix or with num lock off.
    assign nav        = nav_code(i_code);
    assign nav_enable = (i_state.previous_code == CODE_EXTEND) || !i_state.num_lock;
    assign in_table   = (i_code < 8'(TABLE_LEN));

    // Table lookup with caps lock swapping the case of letters.
    always_comb begin
        ch = i_state.shift_held ? SHIFT_MAP[i_code] : PLAIN_MAP[i_code];
        ch_case = ch;
        if (i_state.caps_lock) begin
            if (ch inside {[8'h61:8'h7A]}) begin
                ch_case = ch - CASE_FLIP;
            end else if (ch inside {[8'h41:8'h5A]}) begin
                ch_case = ch + CASE_FLIP;
            end
        end
    end

    // Byte decode and state update.
    always_comb begin
        o_state        = i_state;
        o_result.emit  = 1'b0;
        o_result.kind  = KIND_CHAR;
        o_result.value = 8'd0;
        if (i_code == CODE_NONE) begin
            o_state = i_state;
        end else if (i_code == CODE_ACK) begin
            o_state.previous_code = i_code;
            o_result.emit = 1'b1;
            o_result.kind = KIND_ACK;
        end else if (i_state.previous_code == CODE_BREAK && i_code == CODE_EXTEND) begin
            // A break followed by extend is skipped; the break stays pending.
            o_state = i_state;
        end else if (i_state.previous_code == CODE_BREAK) begin
            o_state.previous_code = i_code;
            if (i_code == CODE_LSHIFT || i_code == CODE_RSHIFT) begin
                o_state.shift_held = 1'b0;
            end
            if (i_code == CODE_CTRL) begin
                o_state.ctrl_held = 1'b0;
            end
        end else begin
            o_state.previous_code = i_code;
            if (nav_enable && nav != 8'd0) begin
                o_result.emit  = 1'b1;
                o_result.value = nav;
            end else if (i_code == CODE_LSHIFT || i_code == CODE_RSHIFT) begin
                o_state.shift_held = 1'b1;
            end else if (i_code == CODE_CTRL) begin
                o_state.ctrl_held = 1'b1;
            end else if (i_code == CODE_ALT) begin
                o_state.ctrl_held = i_state.ctrl_held;
            end else if (i_code == CODE_CAPS || i_code == CODE_NUM
                         || i_code == CODE_SCROLL) begin
                if (i_code == CODE_CAPS) begin
                    o_state.caps_lock = !i_state.caps_lock;
                end
                if (i_code == CODE_NUM) begin
                    o_state.num_lock = !i_state.num_lock;
                end
                if (i_code == CODE_SCROLL) begin
                    o_state.scroll_lock = !i_state.scroll_lock;
                end
                o_result.emit  = 1'b1;
                o_result.kind  = KIND_LEDS;
                o_result.value = {5'd0, o_state.caps_lock, o_state.num_lock,
                                  o_state.scroll_lock};
            end else if (in_table && ch != 8'd0) begin
                o_result.emit  = 1'b1;
                o_result.value = i_state.ctrl_held ? (ch_case & CTRL_MASK) : ch_case;
            end
        end
    end

endmodule

/* sv/ps2_scancode_to_ascii.sv */
// Keyboard byte decoder for scan code set 2 with a UK layout. Each accepted
// scan code is registered, decoded against the held shift, ctrl and lock
// state, and any result (a character, an LED request after a lock key, or an
// acknowledge on 0xFA) is loaded into the output register. One beat is taken
// every cycle while the output beat is not stalled; the rate is set by the
// single decode stage, which updates the keyboard state and the output
// register in the same cycle. Prefix, modifier and break bytes give no output
// beat, and while the output beat is stalled the input register holds at most
// one further byte.
module ps2_scancode_to_ascii (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_scan_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_value
);
    import ps2sa_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_code;
    t_kbd_state r_state;
    t_kbd_state n_state;
    t_result    n_result;
    logic       r_out_valid;
    logic [1:0] r_out_kind;
    logic [7:0] r_out_value;
    logic       out_free;
    logic       advance;

    // The decode stage moves when the output register is empty or draining.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_code <= i_scan_code;
        end
    end

    ps2sa_decode u_decode (
        .i_code   (r_in_code),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Keyboard state follows every decoded byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_result.emit) begin
            r_out_kind  <= n_result.kind;
            r_out_value <= n_result.value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_value     = r_out_value;

endmodule

/* sv/ps2sa_checker.sv */
module ps2sa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_kind,
    input logic [7:0] o_value
);
    import ps2sa_pkg::*;

    // No output beat directly after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) && $stable(o_value))
        else $error("stalled output beat changed");

    // Only the three defined kinds appear.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == KIND_CHAR || o_kind == KIND_LEDS || o_kind == KIND_ACK))
        else $error("undefined result kind");

    // Acknowledge beats carry zero, LED beats only the three lock bits.
    a_ack_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_ACK |-> o_value == 8'd0)
        else $error("acknowledge with nonzero value");

    a_led_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_LEDS |-> o_value[7:3] == 5'd0)
        else $error("LED request with stray bits");

endmodule

bind ps2_scancode_to_ascii ps2sa_checker u_ps2sa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_kind      (o_kind),
    .o_value     (o_value)
);
